[rtl/lamport_multi_slot_admission_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef LAMPORT_MULTI_SLOT_ADMISSION_TOP_ASSERT_SVH
`define LAMPORT_MULTI_SLOT_ADMISSION_TOP_ASSERT_SVH

// Implication checked every cycle outside reset.
`define LMSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define LMSA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/lmsa_pkg.sv]
package lmsa_pkg;

   localparam int QueueDepthDef = 16;
   localparam int StampBitsDef  = 32;

   localparam logic [2:0] KIND_PEER_REQ = 3'd0;
   localparam logic [2:0] KIND_PEER_ACK = 3'd1;
   localparam logic [2:0] KIND_PEER_REL = 3'd2;
   localparam logic [2:0] KIND_LOC_REQ  = 3'd3;
   localparam logic [2:0] KIND_LOC_EXIT = 3'd4;

   localparam logic [1:0] SEND_NONE = 2'd0;
   localparam logic [1:0] SEND_ACK  = 2'd1;
   localparam logic [1:0] SEND_REQ  = 2'd2;
   localparam logic [1:0] SEND_REL  = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_CS   = 2'd2;

   localparam logic [1:0] CSR_NODE_ID    = 2'd0;
   localparam logic [1:0] CSR_NODE_COUNT = 2'd1;
   localparam logic [1:0] CSR_SLOT_LIMIT = 2'd2;
   localparam logic [1:0] CSR_UNIT_LIMIT = 2'd3;

   localparam logic [4:0] ACK_MAX = 5'd31;

   // controller -> datapath
   typedef struct packed {
      logic load;      // latch input item
      logic insert;    // peer insert or own insert
      logic remove;    // remove step
      logic scan;      // entry scan step
      logic finish;    // compute result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

[rtl/lamport_multi_slot_admission_top.sv]
// Admission engine of one node for Lamport-style mutual exclusion over
// several slots and a shared pool of units.
// Input channel req_*: one message or local command per item (valid/ready).
// Result channel rsp_*: exactly one result item per input item.
// csr_*: register writes (node id, node count, slot limit, unit limit), to be
// taken only while no item is in flight; the block itself does not enforce this.
// An accepted item passes the update step (insert or remove), the scan of the
// request queue, one entry per cycle, up to and including this node's own entry
// (at most QUEUE_DEPTH entries), the finish step and the output state. One item
// is in flight at a time, so the next item is accepted only after the previous
// result has been taken.
// Reset clears the clock, queue count, ack count and phase; registers take
// their default values. Queue contents need no clearing.
// While rsp_ready is low the result holds and req_ready stays low.
module lamport_multi_slot_admission_top #(
   parameter int QUEUE_DEPTH = lmsa_pkg::QueueDepthDef,
   parameter int STAMP_BITS  = lmsa_pkg::StampBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_msg_timestamp,
   input  logic [3:0]  req_msg_node,
   input  logic [2:0]  req_msg_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_send_kind,
   output logic [3:0]  rsp_send_dest,
   output logic [31:0] rsp_send_timestamp,
   output logic [2:0]  rsp_send_amount,
   output logic [1:0]  rsp_node_state,
   output logic        rsp_entered,
   output logic        rsp_rejected,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   lmsa_pkg::cmd_type cmd;
   lmsa_pkg::sts_type sts;

   lmsa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   lmsa_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .STAMP_BITS(STAMP_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_kind(req_kind), .req_msg_timestamp(req_msg_timestamp),
      .req_msg_node(req_msg_node), .req_msg_amount(req_msg_amount),
      .rsp_send_kind(rsp_send_kind), .rsp_send_dest(rsp_send_dest),
      .rsp_send_timestamp(rsp_send_timestamp), .rsp_send_amount(rsp_send_amount),
      .rsp_node_state(rsp_node_state), .rsp_entered(rsp_entered),
      .rsp_rejected(rsp_rejected)
   );

endmodule

[rtl/lmsa_ctrl.sv]
module lmsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  lmsa_pkg::sts_type  sts,
   output lmsa_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.insert = 1'b1;
            cmd.remove = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

[rtl/lmsa_datapath.sv]
module lmsa_datapath #(
   parameter int QUEUE_DEPTH = lmsa_pkg::QueueDepthDef,
   parameter int STAMP_BITS  = lmsa_pkg::StampBitsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  lmsa_pkg::cmd_type  cmd,
   output lmsa_pkg::sts_type  sts,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data,
   input  logic [2:0]         req_kind,
   input  logic [31:0]        req_msg_timestamp,
   input  logic [3:0]         req_msg_node,
   input  logic [2:0]         req_msg_amount,
   output logic [1:0]         rsp_send_kind,
   output logic [3:0]         rsp_send_dest,
   output logic [31:0]        rsp_send_timestamp,
   output logic [2:0]         rsp_send_amount,
   output logic [1:0]         rsp_node_state,
   output logic               rsp_entered,
   output logic               rsp_rejected
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 3;
   localparam logic [STAMP_BITS-1:0] SMAX = '1;
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   typedef struct packed {
      logic [STAMP_BITS-1:0] ts;
      logic [3:0]            node;
      logic [2:0]            amt;
   } entry_type;

   entry_type q_ff [QUEUE_DEPTH];

   logic [3:0] node_id_ff;
   logic [4:0] node_count_ff, slot_limit_ff;
   logic [7:0] unit_limit_ff;

   logic [STAMP_BITS-1:0] clock_ff;
   logic [CW-1:0] count_ff;
   logic [4:0] acks_ff;
   logic [1:0] phase_ff;
   logic [2:0] own_ff;

   logic [2:0] kind_ff;
   logic [STAMP_BITS-1:0] mts_ff;
   logic [3:0] mnode_ff;
   logic [2:0] mamt_ff;
   logic rej_ff, ins_ok_ff;

   // scan state
   logic [CW-1:0] idx_ff;
   logic [SW-1:0] sum_ff;
   logic found_ff, ok_ff;

   // received stamp, saturated into STAMP_BITS
   logic [STAMP_BITS-1:0] rx_sat;
   logic [STAMP_BITS-1:0] merged, ticked;
   always_comb begin
      if (STAMP_BITS < 32 && |(req_msg_timestamp >> STAMP_BITS)) rx_sat = SMAX;
      else rx_sat = STAMP_BITS'(req_msg_timestamp);
      merged = (rx_sat > clock_ff) ? rx_sat : clock_ff;
      if (merged != SMAX) merged = merged + 1'b1;
      ticked = (clock_ff != SMAX) ? clock_ff + 1'b1 : clock_ff;
   end

   logic peer;
   assign peer = (req_kind == lmsa_pkg::KIND_PEER_REQ) ||
                 (req_kind == lmsa_pkg::KIND_PEER_ACK) ||
                 (req_kind == lmsa_pkg::KIND_PEER_REL);
   logic full;
   assign full = (count_ff >= DEPTH_C);

   // insert / remove position by parallel compare
   entry_type nent;
   logic [QUEUE_DEPTH-1:0] after, match, first_m, ins_at, rem_sh;
   logic any_m, seen;
   always_comb begin
      nent.ts = (kind_ff == lmsa_pkg::KIND_LOC_REQ) ? clock_ff : mts_ff;
      nent.node = (kind_ff == lmsa_pkg::KIND_LOC_REQ) ? node_id_ff : mnode_ff;
      nent.amt = (kind_ff == lmsa_pkg::KIND_LOC_REQ) ? own_ff : mamt_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         after[i] = (CW'(i) < count_ff) && ((q_ff[i].ts > nent.ts) ||
            (q_ff[i].ts == nent.ts && q_ff[i].node > nent.node));
         match[i] = (CW'(i) < count_ff) &&
            (q_ff[i].node == ((kind_ff == lmsa_pkg::KIND_LOC_EXIT) ?
                              node_id_ff : mnode_ff));
      end
      // entries are sorted, so "after" is a suffix; new entry lands at its start
      ins_at[0] = after[0] || (!(|after) && count_ff == '0);
      for (int i = 1; i < QUEUE_DEPTH; i++)
         ins_at[i] = (after[i] && !after[i-1]) || (!(|after) && CW'(i) == count_ff);
      // first match, and every slot from it upward shifts down on removal
      seen = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         first_m[i] = match[i] & ~seen;
         seen = seen | match[i];
         rem_sh[i] = seen;
      end
      any_m = seen;
   end

   logic do_ins, do_rem;
   assign do_ins = cmd.insert && ins_ok_ff;
   assign do_rem = cmd.remove && !rej_ff && any_m &&
      ((kind_ff == lmsa_pkg::KIND_PEER_REL) || (kind_ff == lmsa_pkg::KIND_LOC_EXIT));

   always_ff @(posedge clock) begin
      if (do_ins) begin
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (after[i-1]) q_ff[i] <= q_ff[i-1];
         end
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (ins_at[i]) q_ff[i] <= nent;
         end
      end else if (do_rem) begin
         for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
            if (rem_sh[i]) q_ff[i] <= q_ff[i + 1];
         end
      end
   end

   // scan over queue: find own entry, prefix sum of amounts ahead
   logic [IW-1:0] sidx;
   assign sidx = idx_ff[IW-1:0];
   logic scan_end;
   assign scan_end = found_ff || (idx_ff >= count_ff);
   assign sts.scan_done = scan_end;

   logic [4:0] needed;
   assign needed = (node_count_ff == 5'd0) ? 5'd0 : node_count_ff - 5'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= '0;
         node_count_ff <= 5'd2;
         slot_limit_ff <= 5'd2;
         unit_limit_ff <= 8'd10;
         clock_ff <= '0;
         count_ff <= '0;
         acks_ff <= '0;
         phase_ff <= lmsa_pkg::PH_IDLE;
         own_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               lmsa_pkg::CSR_NODE_ID:    node_id_ff <= csr_data[3:0];
               lmsa_pkg::CSR_NODE_COUNT: node_count_ff <= csr_data[4:0];
               lmsa_pkg::CSR_SLOT_LIMIT: slot_limit_ff <= csr_data[4:0];
               lmsa_pkg::CSR_UNIT_LIMIT: unit_limit_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load) begin
            case (req_kind)
               lmsa_pkg::KIND_PEER_ACK: begin
                  clock_ff <= merged;
                  if (acks_ff < lmsa_pkg::ACK_MAX) acks_ff <= acks_ff + 5'd1;
               end
               lmsa_pkg::KIND_PEER_REQ, lmsa_pkg::KIND_PEER_REL: clock_ff <= merged;
               lmsa_pkg::KIND_LOC_REQ:
                  if (phase_ff == lmsa_pkg::PH_IDLE && !full) begin
                     clock_ff <= ticked;
                     own_ff <= req_msg_amount;
                     acks_ff <= '0;
                     phase_ff <= lmsa_pkg::PH_WAIT;
                  end
               lmsa_pkg::KIND_LOC_EXIT:
                  if (phase_ff == lmsa_pkg::PH_CS) begin
                     clock_ff <= ticked;
                     phase_ff <= lmsa_pkg::PH_IDLE;
                  end
               default: ;
            endcase
         end
         if (do_ins) count_ff <= count_ff + 1'b1;
         else if (do_rem) count_ff <= count_ff - 1'b1;
         if (cmd.finish && phase_ff == lmsa_pkg::PH_WAIT && ok_ff)
            phase_ff <= lmsa_pkg::PH_CS;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         mts_ff <= peer ? rx_sat : '0;
         mnode_ff <= req_msg_node;
         mamt_ff <= req_msg_amount;
         rej_ff <= ((req_kind == lmsa_pkg::KIND_LOC_REQ) &&
                    (phase_ff != lmsa_pkg::PH_IDLE || full)) ||
                   ((req_kind == lmsa_pkg::KIND_LOC_EXIT) &&
                    (phase_ff != lmsa_pkg::PH_CS)) ||
                   ((req_kind == lmsa_pkg::KIND_PEER_REQ) && full);
         ins_ok_ff <= !full && ((req_kind == lmsa_pkg::KIND_PEER_REQ) ||
                    (req_kind == lmsa_pkg::KIND_LOC_REQ && phase_ff == lmsa_pkg::PH_IDLE));
      end
      if (cmd.insert) begin
         idx_ff <= '0;
         sum_ff <= '0;
         found_ff <= 1'b0;
         ok_ff <= 1'b0;
      end else if (cmd.scan && !scan_end) begin
         if (q_ff[sidx].node == node_id_ff) begin
            found_ff <= 1'b1;
            ok_ff <= (32'(idx_ff) < 32'(slot_limit_ff)) &&
                     ((32'(sum_ff) + 32'(own_ff)) <= 32'(unit_limit_ff)) &&
                     (acks_ff == needed);
         end else begin
            sum_ff <= sum_ff + SW'(q_ff[sidx].amt);
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.finish) begin
         rsp_rejected <= rej_ff;
         rsp_send_dest <= '0;
         rsp_send_amount <= '0;
         rsp_send_timestamp <= '0;
         rsp_send_kind <= lmsa_pkg::SEND_NONE;
         rsp_entered <= phase_ff == lmsa_pkg::PH_WAIT && ok_ff;
         rsp_node_state <= (phase_ff == lmsa_pkg::PH_WAIT && ok_ff) ?
                           lmsa_pkg::PH_CS : phase_ff;
         if (!rej_ff) begin
            case (kind_ff)
               lmsa_pkg::KIND_PEER_REQ: begin
                  rsp_send_kind <= lmsa_pkg::SEND_ACK;
                  rsp_send_dest <= mnode_ff;
                  rsp_send_timestamp <= 32'(clock_ff);
               end
               lmsa_pkg::KIND_LOC_REQ: begin
                  rsp_send_kind <= lmsa_pkg::SEND_REQ;
                  rsp_send_timestamp <= 32'(clock_ff);
                  rsp_send_amount <= own_ff;
               end
               lmsa_pkg::KIND_LOC_EXIT: begin
                  rsp_send_kind <= lmsa_pkg::SEND_REL;
                  rsp_send_timestamp <= 32'(clock_ff);
               end
               default: ;
            endcase
         end
      end
   end

endmodule

[rtl/lmsa_checker.sv]
`include "lamport_multi_slot_admission_top_assert.svh"

module lmsa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_send_kind,
   input logic [1:0] rsp_node_state,
   input logic       rsp_entered,
   input logic       rsp_rejected
);

   // one item in flight: no new accept while a result is shown
   `LMSA_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // an accepted item is not answered in the next cycle
   `LMSA_ASSERT_NXT(a_min_latency, clock, reset, req_valid && req_ready, !rsp_valid)
   // a stalled result stays offered
   `LMSA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `LMSA_ASSERT_IMP(a_enter_cs, clock, reset, rsp_valid && rsp_entered,
                    rsp_node_state == lmsa_pkg::PH_CS)
   `LMSA_ASSERT_IMP(a_rej_quiet, clock, reset, rsp_valid && rsp_rejected,
                    rsp_send_kind == lmsa_pkg::SEND_NONE)

endmodule

bind lamport_multi_slot_admission_top lmsa_checker u_lmsa_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_send_kind(rsp_send_kind),
   .rsp_node_state(rsp_node_state), .rsp_entered(rsp_entered),
   .rsp_rejected(rsp_rejected)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int QDEPTH = 16;
   localparam logic [31:0] STAMP_TOP = 32'hFFFF_FFFF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] KIND_POLL = 3'd5;

   typedef struct packed {
      logic [1:0]  send_kind;
      logic [3:0]  send_dest;
      logic [31:0] send_timestamp;
      logic [2:0]  send_amount;
      logic [1:0]  node_state;
      logic        entered;
      logic        rejected;
   } outcome_type;

   typedef struct packed {
      logic [31:0] ts;
      logic [3:0]  node;
      logic [2:0]  amt;
   } queue_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [31:0] req_msg_timestamp = '0;
   logic [3:0]  req_msg_node = '0;
   logic [2:0]  req_msg_amount = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_send_kind;
   logic [3:0]  rsp_send_dest;
   logic [31:0] rsp_send_timestamp;
   logic [2:0]  rsp_send_amount;
   logic [1:0]  rsp_node_state;
   logic        rsp_entered;
   logic        rsp_rejected;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   lamport_multi_slot_admission_top u_top (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [3:0]      my_id;
   logic [4:0]      peer_total;
   logic [4:0]      slots;
   logic [7:0]      units;
   logic [31:0]     lclock;
   queue_entry_type pending [QDEPTH];
   int              pending_cnt;
   logic [4:0]      acks;
   logic [1:0]      phase;
   logic [2:0]      own_amt;

   outcome_type expected_outcomes [$];
   int  errors = 0;
   bit  no_idle = 1'b0;
   int  idle_cycles = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic void tick_clock();
      if (lclock != STAMP_TOP) lclock++;
   endfunction

   function automatic void merge_clock(logic [31:0] rx);
      if (rx > lclock) lclock = rx;
      tick_clock();
   endfunction

   function automatic bit insert_entry(logic [31:0] ts, logic [3:0] node, logic [2:0] amt);
      int pos;
      pos = 0;
      if (pending_cnt >= QDEPTH) return 1'b0;
      while (pos < pending_cnt) begin
         if (pending[pos].ts > ts || (pending[pos].ts == ts && pending[pos].node > node)) break;
         pos++;
      end
      for (int i = pending_cnt; i > pos; i--) pending[i] = pending[i-1];
      pending[pos] = '{ts, node, amt};
      pending_cnt++;
      return 1'b1;
   endfunction

   function automatic void remove_entry(logic [3:0] node);
      for (int i = 0; i < pending_cnt; i++) begin
         if (pending[i].node == node) begin
            for (int j = i; j + 1 < pending_cnt; j++) pending[j] = pending[j+1];
            pending_cnt--;
            return;
         end
      end
   endfunction

   function automatic bit can_enter();
      int needed;
      int sum;
      needed = (peer_total == 0) ? 0 : peer_total - 1;
      sum = 0;
      if (acks != needed) return 1'b0;
      for (int i = 0; i < pending_cnt; i++) begin
         if (pending[i].node == my_id) return (i < slots) && (sum + own_amt <= units);
         sum += pending[i].amt;
      end
      return 1'b0;
   endfunction

   function automatic outcome_type admit_item(logic [2:0] kind, logic [31:0] ts,
                                              logic [3:0] node, logic [2:0] amt);
      outcome_type o;
      o = '0;
      case (kind)
         lmsa_pkg::KIND_PEER_REQ: begin
            merge_clock(ts);
            if (insert_entry(ts, node, amt)) begin
               o.send_kind = lmsa_pkg::SEND_ACK;
               o.send_dest = node;
               o.send_timestamp = lclock;
            end else o.rejected = 1'b1;
         end
         lmsa_pkg::KIND_PEER_ACK: begin
            merge_clock(ts);
            if (acks < lmsa_pkg::ACK_MAX) acks++;
         end
         lmsa_pkg::KIND_PEER_REL: begin
            merge_clock(ts);
            remove_entry(node);
         end
         lmsa_pkg::KIND_LOC_REQ: begin
            if (phase != lmsa_pkg::PH_IDLE || pending_cnt >= QDEPTH) o.rejected = 1'b1;
            else begin
               tick_clock();
               own_amt = amt;
               void'(insert_entry(lclock, my_id, own_amt));
               acks = 0;
               phase = lmsa_pkg::PH_WAIT;
               o.send_kind = lmsa_pkg::SEND_REQ;
               o.send_timestamp = lclock;
               o.send_amount = own_amt;
            end
         end
         lmsa_pkg::KIND_LOC_EXIT: begin
            if (phase != lmsa_pkg::PH_CS) o.rejected = 1'b1;
            else begin
               tick_clock();
               remove_entry(my_id);
               phase = lmsa_pkg::PH_IDLE;
               o.send_kind = lmsa_pkg::SEND_REL;
               o.send_timestamp = lclock;
            end
         end
         default: ;
      endcase
      if (phase == lmsa_pkg::PH_WAIT && can_enter()) begin
         phase = lmsa_pkg::PH_CS;
         o.entered = 1'b1;
      end
      o.node_state = phase;
      return o;
   endfunction

   // within this task valid drops only while idling, so it is never assigned twice in one step
   task automatic send_item(input logic [2:0] kind, input logic [31:0] ts,
                            input logic [3:0] node, input logic [2:0] amt);
      while (!no_idle && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_msg_timestamp <= ts;
      req_msg_node <= node;
      req_msg_amount <= amt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_outcomes.push_back(admit_item(kind, ts, node, amt));
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      case (idx)
         lmsa_pkg::CSR_NODE_ID:    my_id = val[3:0];
         lmsa_pkg::CSR_NODE_COUNT: peer_total = val[4:0];
         lmsa_pkg::CSR_SLOT_LIMIT: slots = val[4:0];
         default:                  units = val;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(negedge clock);
      repeat (QDEPTH + 10) @(negedge clock);
   endtask

   task automatic configure(input logic [3:0] id, input logic [4:0] cnt,
                            input logic [4:0] sl, input logic [7:0] ul);
      drain();
      write_reg(lmsa_pkg::CSR_NODE_ID, {4'd0, id});
      write_reg(lmsa_pkg::CSR_NODE_COUNT, {3'd0, cnt});
      write_reg(lmsa_pkg::CSR_SLOT_LIMIT, {3'd0, sl});
      write_reg(lmsa_pkg::CSR_UNIT_LIMIT, ul);
      csr_write <= 1'b0;
   endtask

   function automatic logic [2:0] pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 30) return lmsa_pkg::KIND_PEER_REQ;
      if (r < 50) return lmsa_pkg::KIND_PEER_ACK;
      if (r < 68) return lmsa_pkg::KIND_PEER_REL;
      if (r < 80) return lmsa_pkg::KIND_LOC_REQ;
      if (r < 92) return lmsa_pkg::KIND_LOC_EXIT;
      return 3'($urandom_range(7, 5));
   endfunction

   function automatic logic [31:0] pick_stamp();
      case ($urandom_range(5))
         0: return $urandom;
         1: return STAMP_TOP - $urandom_range(3);
         default: return lclock + $urandom_range(6) - 2;
      endcase
   endfunction

   task automatic test_directed();
      send_item(KIND_POLL, 32'd0, 4'd0, 3'd0);
      send_item(lmsa_pkg::KIND_LOC_EXIT, 32'd0, 4'd0, 3'd0);
      send_item(lmsa_pkg::KIND_LOC_REQ, 32'd0, 4'd0, 3'd7);
      send_item(lmsa_pkg::KIND_LOC_REQ, 32'd0, 4'd0, 3'd1);
      send_item(lmsa_pkg::KIND_PEER_REQ, 32'd1, 4'd15, 3'd7);
      send_item(lmsa_pkg::KIND_PEER_REQ, 32'd1, 4'd15, 3'd2);
      send_item(lmsa_pkg::KIND_PEER_ACK, 32'd0, 4'd3, 3'd0);
      send_item(lmsa_pkg::KIND_PEER_ACK, 32'd0, 4'd3, 3'd0);
      send_item(lmsa_pkg::KIND_PEER_REL, 32'd5, 4'd15, 3'd0);
      send_item(lmsa_pkg::KIND_PEER_REL, 32'd5, 4'd15, 3'd0);
      send_item(3'd6, 32'd0, 4'd0, 3'd0);
      send_item(3'd7, 32'hFFFF_FFFF, 4'd15, 3'd7);
      send_item(lmsa_pkg::KIND_LOC_EXIT, 32'd0, 4'd0, 3'd0);
      send_item(lmsa_pkg::KIND_PEER_REL, 32'd0, 4'd0, 3'd0);
      // saturate the clock, then fill the queue
      send_item(lmsa_pkg::KIND_PEER_ACK, STAMP_TOP, 4'd1, 3'd0);
      for (int i = 0; i < QDEPTH + 1; i++)
         send_item(lmsa_pkg::KIND_PEER_REQ, STAMP_TOP, 4'(i), 3'(i));
      send_item(lmsa_pkg::KIND_LOC_REQ, 32'd0, 4'd0, 3'd3);
   endtask

   task automatic test_config_sweep();
      configure(4'd15, 5'd16, 5'd16, 8'd255);
      for (int i = 0; i < QDEPTH; i++)
         send_item(lmsa_pkg::KIND_PEER_REL, 32'd0, 4'(i), 3'd0);
      send_item(lmsa_pkg::KIND_LOC_REQ, 32'd0, 4'd0, 3'd0);
      repeat (33) send_item(lmsa_pkg::KIND_PEER_ACK, 32'h5555_AAAA, 4'd0, 3'd0);
      send_item(lmsa_pkg::KIND_LOC_EXIT, 32'd0, 4'd0, 3'd0);
      configure(4'd0, 5'd0, 5'd0, 8'd0);
      send_item(lmsa_pkg::KIND_LOC_REQ, 32'd0, 4'd0, 3'd5);
      send_item(lmsa_pkg::KIND_PEER_REL, 32'd0, 4'd0, 3'd0);
   endtask

   task automatic random_phase(input int count);
      logic [2:0] k;
      for (int n = 0; n < count; n++) begin
         k = pick_kind();
         if (k == lmsa_pkg::KIND_PEER_REQ && pending_cnt > 10 && $urandom_range(1))
            k = lmsa_pkg::KIND_PEER_REL;
         send_item(k, pick_stamp(), 4'($urandom_range(peer_total > 0 ? 15 : 3)),
                   3'($urandom));
      end
   endtask

   task automatic test_random();
      configure(4'd2, 5'd3, 5'd2, 8'd10);
      random_phase(300);
      configure(4'($urandom), 5'($urandom_range(16)), 5'($urandom_range(16)), 8'($urandom));
      random_phase(250);
      no_idle = 1'b1;
      configure(4'd7, 5'd1, 5'd16, 8'd255);
      random_phase(200);
      no_idle = 1'b0;
      configure(4'd4, 5'd2, 5'd1, 8'd4);
      random_phase(300);
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) report("unexpected result", 0, 0);
         else begin
            want = expected_outcomes.pop_front();
            if (rsp_send_kind != want.send_kind) report("send_kind", rsp_send_kind, want.send_kind);
            if (rsp_send_dest != want.send_dest) report("send_dest", rsp_send_dest, want.send_dest);
            if (rsp_send_timestamp != want.send_timestamp)
               report("send_timestamp", rsp_send_timestamp, want.send_timestamp);
            if (rsp_send_amount != want.send_amount)
               report("send_amount", rsp_send_amount, want.send_amount);
            if (rsp_node_state != want.node_state)
               report("node_state", rsp_node_state, want.node_state);
            if (rsp_entered != want.entered) report("entered", rsp_entered, want.entered);
            if (rsp_rejected != want.rejected) report("rejected", rsp_rejected, want.rejected);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      my_id = 0; peer_total = 2; slots = 2; units = 10;
      lclock = 0; pending_cnt = 0; acks = 0; phase = lmsa_pkg::PH_IDLE; own_amt = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_random();
      drain();
      if (errors == 0 && expected_outcomes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/lmsa_pkg.sv
rtl/lmsa_ctrl.sv
rtl/lmsa_datapath.sv
rtl/lamport_multi_slot_admission_top.sv
rtl/lmsa_checker.sv
tb/tb.sv
